[sv/cmg_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar month grid package
// Grid constants, register indexes, reciprocal constants, month tables and
// the structs that travel between the date unit, the cell sequencer and top.
// ----------------------------------------------------------------------------
package cmg_pkg;

  localparam int GRID_ROWS     = 6;
  localparam int GRID_COLS     = 7;
  localparam int GLYPH_WIDTH   = 8;
  localparam int GRID_ORIGIN_Y = 80;
  localparam int DIGIT_HEIGHT  = 32;

  // Register indexes on the configuration port
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [9:0] SCREEN_W_RST = 10'd320;
  localparam logic [9:0] SCREEN_H_RST = 10'd480;

  // Reciprocals: x/100 = (x*5243)>>19 for x < 16384,
  // x/7 = (x*37450)>>18 for x < 21000, w/7 = (w*1171)>>13, g/6 = (g*683)>>12
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam logic [15:0] RECIP_7      = 16'd37450;
  localparam logic [10:0] RECIP_7_PX   = 11'd1171;
  localparam logic [9:0]  RECIP_6_PX   = 10'd683;

  // Per-request values handed from the date unit to the cell sequencer
  typedef struct packed {
    logic [2:0] skip;        // weekday of the first, leading blank count
    logic [4:0] dim;         // days in the month
    logic       date_match;  // view year and month equal today's
    logic [4:0] today_day;
  } params_t;

  // Screen geometry held at the top level
  typedef struct packed {
    logic [9:0] scr_w;
    logic [9:0] scr_h;
    logic [7:0] cell_w;
    logic [7:0] cell_h;
  } geom_t;

  // Sakamoto month offsets, January first
  function automatic logic [2:0] sak_offset(input logic [3:0] m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // Days per month in a common year; meaningless months give 31
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[sv/cmg_date.sv]
// ----------------------------------------------------------------------------
// Calendar month date unit
// Four-stage stallable pipeline: input register, year/100, weekday sum,
// weekday mod 7. Holds the finished request values until the sequencer takes
// them.
// ----------------------------------------------------------------------------
module cmg_date (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [13:0]      view_year,
  input  logic [3:0]       req_month,
  input  logic [6:0]       today_year_low,
  input  logic [3:0]       today_month,
  input  logic [4:0]       today_day,
  output cmg_pkg::params_t prm,
  output logic             prm_valid,
  input  logic             prm_take
);
  import cmg_pkg::*;

  logic v0_r, v1_r, v2_r, v3_r;
  logic mv1, mv2, mv3, acc;

  logic [13:0] vy0_r;
  logic [3:0]  vm0_r, tm0_r;
  logic [6:0]  tyl0_r;
  logic [4:0]  td0_r;

  logic [13:0] vy1_r;
  logic [3:0]  vm1_r;
  logic [7:0]  q1_r;
  logic        dm1_r;
  logic [4:0]  td1_r;

  logic [14:0] s2_r;
  logic [4:0]  dim2_r;
  logic        dm2_r;
  logic [4:0]  td2_r;

  params_t     prm_r;

  // Advance each stage when the next one is empty or moving on
  assign mv3       = v2_r && (!v3_r || prm_take);
  assign mv2       = v1_r && (!v2_r || mv3);
  assign mv1       = v0_r && (!v1_r || mv2);
  assign in_tready = !v0_r || mv1;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= acc || (v0_r && !mv1);
      v1_r <= mv1 || (v1_r && !mv2);
      v2_r <= mv2 || (v2_r && !mv3);
      v3_r <= mv3 || (v3_r && !prm_take);
    end
  end

  // Stage 0: capture the request
  always_ff @(posedge clk) begin
    if (acc) begin
      vy0_r  <= view_year;
      vm0_r  <= req_month;
      tyl0_r <= today_year_low;
      tm0_r  <= today_month;
      td0_r  <= today_day;
    end
  end

  // Stage 1: year / 100 and today's year compare
  logic [26:0] p100;
  logic [6:0]  tyl_mod;
  logic [13:0] ty_full;
  assign p100    = {13'b0, vy0_r} * {14'b0, RECIP_100};
  assign tyl_mod = (tyl0_r >= 7'd100) ? (tyl0_r - 7'd100) : tyl0_r;
  assign ty_full = 14'd2000 + {7'b0, tyl_mod};

  always_ff @(posedge clk) begin
    if (mv1) begin
      vy1_r <= vy0_r;
      vm1_r <= vm0_r;
      q1_r  <= p100[26:19];
      dm1_r <= (vy0_r == ty_full) && (vm0_r == tm0_r);
      td1_r <= td0_r;
    end
  end

  // Stage 2: leap rule, month length and the Sakamoto sum
  logic [13:0] q1x100, r100, y_t;
  logic        mvalid, early, leap, yneg;
  logic [7:0]  qy;
  logic [4:0]  dim_t;
  logic [14:0] s_t;
  logic [2:0]  off;

  assign q1x100 = {6'b0, q1_r} * 14'd100;
  assign r100   = vy1_r - q1x100;
  assign leap   = (r100 == 14'd0) ? (q1_r[1:0] == 2'd0) : (vy1_r[1:0] == 2'd0);
  assign mvalid = (vm1_r >= 4'd1) && (vm1_r <= 4'd12);
  assign early  = mvalid && (vm1_r < 4'd3);
  assign yneg   = early && (vy1_r == 14'd0);
  assign y_t    = early ? (vy1_r - 14'd1) : vy1_r;
  assign qy     = (early && (r100 == 14'd0)) ? (q1_r - 8'd1) : q1_r;
  assign off    = sak_offset(vm1_r);

  always_comb begin
    if (!mvalid) begin
      dim_t = 5'd31;
    end else if ((vm1_r == 4'd2) && leap) begin
      dim_t = 5'd29;
    end else begin
      dim_t = month_len(vm1_r);
    end
    if (!mvalid) begin
      s_t = 15'd0;
    end else if (yneg) begin
      // year -1: all quotient terms truncate to zero, the sum is the offset
      s_t = {12'b0, off};
    end else begin
      s_t = {1'b0, y_t} + {3'b0, y_t[13:2]} - {7'b0, qy} + {9'b0, qy[7:2]}
            + {12'b0, off} + 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s2_r   <= s_t;
      dim2_r <= dim_t;
      dm2_r  <= dm1_r;
      td2_r  <= td1_r;
    end
  end

  // Stage 3: weekday = sum mod 7
  logic [30:0] p7;
  logic [11:0] q7;
  logic [14:0] q7x7, r7;
  assign p7   = {16'b0, s2_r} * {15'b0, RECIP_7};
  assign q7   = p7[29:18];
  assign q7x7 = {3'b0, q7} * 15'd7;
  assign r7   = s2_r - q7x7;

  always_ff @(posedge clk) begin
    if (mv3) begin
      prm_r.skip       <= r7[2:0];
      prm_r.dim        <= dim2_r;
      prm_r.date_match <= dm2_r;
      prm_r.today_day  <= td2_r;
    end
  end

  assign prm       = prm_r;
  assign prm_valid = v3_r;

  // Weekday always lands in 0..6
  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (prm_r.skip <= 3'd6))
    else $error("weekday out of range");

endmodule

[sv/cmg_cell.sv]
// ----------------------------------------------------------------------------
// Calendar month cell sequencer
// Walks the 6x7 grid one cell per cycle, unless out_tready stalls it, with running
// row, column, day and pixel counters and builds each cell into the output register.
// ----------------------------------------------------------------------------
module cmg_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  cmg_pkg::params_t prm,
  input  logic             prm_valid,
  output logic             prm_take,
  input  cmg_pkg::geom_t   geom,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  output logic             out_tlast
);
  import cmg_pkg::*;

  localparam logic [2:0] LAST_ROW = 3'(GRID_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(GRID_COLS - 1);

  logic              run_r;
  logic [2:0]        row_r, col_r;
  logic signed [6:0] day_r;
  logic [9:0]        x0_r, y0_r;
  params_t           prm_r;

  logic              out_tvalid_r;
  logic [71:0]       out_tdata_r;
  logic              out_tlast_r;

  logic adv, last, load;

  assign adv      = run_r && (!out_tvalid_r || out_tready);
  assign last     = (row_r == LAST_ROW) && (col_r == LAST_COL);
  assign load     = prm_valid && (!run_r || (adv && last));
  assign prm_take = load;

  // Start a run on new request values, else step through the grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (load) begin
      run_r <= 1'b1;
    end else if (adv && last) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prm_r <= prm;
      row_r <= 3'd0;
      col_r <= 3'd0;
      day_r <= 7'sd1 - $signed({4'b0, prm.skip});
      x0_r  <= 10'd0;
      y0_r  <= 10'(GRID_ORIGIN_Y);
    end else if (adv) begin
      day_r <= day_r + 7'sd1;
      if (col_r == LAST_COL) begin
        col_r <= 3'd0;
        x0_r  <= 10'd0;
        row_r <= row_r + 3'd1;
        y0_r  <= y0_r + {2'b0, geom.cell_h};
      end else begin
        col_r <= col_r + 3'd1;
        x0_r  <= x0_r + {2'b0, geom.cell_w};
      end
    end
  end

  // Cell rectangle, with the last column and row reaching the screen edge
  logic signed [12:0] x0s, y0s, x1, y1, wlen, hlen, dw, nx, ny, hx, hy, tx, ty;
  logic               inm, today, shown;

  assign x0s  = $signed({3'b0, x0_r});
  assign y0s  = $signed({3'b0, y0_r});
  assign x1   = (col_r == LAST_COL) ? ($signed({3'b0, geom.scr_w}) - 13'sd1)
                                    : (x0s + $signed({5'b0, geom.cell_w}) - 13'sd1);
  assign y1   = (row_r == LAST_ROW) ? ($signed({3'b0, geom.scr_h}) - 13'sd1)
                                    : (y0s + $signed({5'b0, geom.cell_h}) - 13'sd1);
  assign wlen = x1 - x0s + 13'sd1;
  assign hlen = y1 - y0s + 13'sd1;

  // Centered text origin, halving with truncation toward zero
  assign inm = (day_r >= 7'sd1) && (day_r <= $signed({2'b0, prm_r.dim}));
  assign dw  = (day_r >= 7'sd10) ? 13'(4 * GLYPH_WIDTH) : 13'(2 * GLYPH_WIDTH);
  assign nx  = wlen - dw;
  assign ny  = hlen - 13'(DIGIT_HEIGHT);
  assign hx  = (nx + $signed({12'b0, nx[12]})) >>> 1;
  assign hy  = (ny + $signed({12'b0, ny[12]})) >>> 1;
  assign tx  = x0s + hx;
  assign ty  = y0s + hy;

  assign today = inm && prm_r.date_match && (day_r[4:0] == prm_r.today_day);
  assign shown = inm && !tx[12] && !ty[12];

  // Load the output register when it is free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {shown,
                      inm ? ty[10:0] : 11'd0,
                      inm ? tx[10:0] : 11'd0,
                      y1[9:0], x1[9:0], y0_r, x0_r,
                      today, inm, day_r};
      out_tlast_r <= last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last && !prm_valid) |=> !run_r)
    else $error("run did not stop after the last cell");

  a_in_month_day: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[7]) |->
      ($signed(out_tdata_r[6:0]) >= 7'sd1 && $signed(out_tdata_r[6:0]) <= 7'sd31))
    else $error("in-month cell with bad day number");

  a_today_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tdata_r[8] || out_tdata_r[71])) |-> out_tdata_r[7])
    else $error("today or text flag outside the month");

  a_last_day: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |-> (day_r == 7'sd42 - $signed({4'b0, prm_r.skip})))
    else $error("day counter out of step with the grid");

endmodule

[sv/calendar_month_grid_generator.sv]
// ----------------------------------------------------------------------------
// Calendar month grid generator
// Takes a year/month request with today's date and streams the 42 cells of
// the month grid, each with day number, flags, rectangle and text origin.
// ----------------------------------------------------------------------------
// First cell word path: date unit pipeline, sequencer counters, output register.
// Throughput: one cell word per cycle from the cell sequencer's output register
//   while out_tready holds; the next request is taken and worked out while the
//   current grid streams.
// Reset: synchronous; screen size returns to 320x480, all words in flight drop.
module calendar_month_grid_generator (
  input  logic        clk,
  input  logic        rst_n,
  // view_year[13:0], view_month[17:14], today_year_low[24:18],
  // today_month[28:25], today_day[33:29], zero fill[39:34]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // day_number[6:0], in_month[7], is_today[8], left_x[18:9], top_y[28:19],
  // right_x[38:29], bottom_y[48:39], text_x[59:49], text_y[70:60],
  // text_shown[71]
  output logic [71:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import cmg_pkg::*;

  logic [9:0] scr_w_r, scr_h_r;
  logic [7:0] cell_w_r, cell_h_r;
  geom_t      geom;
  params_t    prm;
  logic       prm_valid, prm_take;

  // Configuration writes are always accepted and go straight into the registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default:           scr_w_r <= scr_w_r;
      endcase
    end
  end

  // Cell size from the screen size: width / 7, (height - 80) / 6
  logic [20:0] pw;
  logic [9:0]  grid_h;
  logic [19:0] ph;
  assign pw     = {11'b0, scr_w_r} * {10'b0, RECIP_7_PX};
  assign grid_h = (scr_h_r >= 10'(GRID_ORIGIN_Y)) ? (scr_h_r - 10'(GRID_ORIGIN_Y))
                                                  : 10'd0;
  assign ph     = {10'b0, grid_h} * {10'b0, RECIP_6_PX};

  always_ff @(posedge clk) begin
    cell_w_r <= pw[20:13];
    cell_h_r <= ph[19:12];
  end

  assign geom.scr_w  = scr_w_r;
  assign geom.scr_h  = scr_h_r;
  assign geom.cell_w = cell_w_r;
  assign geom.cell_h = cell_h_r;

  cmg_date u_date (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .view_year      (in_tdata[13:0]),
    .req_month      (in_tdata[17:14]),
    .today_year_low (in_tdata[24:18]),
    .today_month    (in_tdata[28:25]),
    .today_day      (in_tdata[33:29]),
    .prm            (prm),
    .prm_valid      (prm_valid),
    .prm_take       (prm_take)
  );

  cmg_cell u_cell (
    .clk        (clk),
    .rst_n      (rst_n),
    .prm        (prm),
    .prm_valid  (prm_valid),
    .prm_take   (prm_take),
    .geom       (geom),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[dv/calendar_month_grid_generator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month grid generator testbench
// Streams month requests through the block under several screen sizes and
// checks every grid cell word against an in-bench prediction of the cell
// layout, weekday of the first, month length and today marker.
// ----------------------------------------------------------------------------
module calendar_month_grid_generator_test;
  import cmg_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int PHASE_REQUESTS = 29;
  localparam int WEEKDAY_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int MONTH_DAYS    [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Request word, lowest field last
  typedef struct packed {
    logic [5:0]  fill;
    logic [4:0]  today_day;
    logic [3:0]  today_month;
    logic [6:0]  today_year_low;
    logic [3:0]  req_month;
    logic [13:0] view_year;
  } request_t;

  // Cell word, lowest field last
  typedef struct packed {
    logic               text_shown;
    logic signed [10:0] text_y;
    logic signed [10:0] text_x;
    logic [9:0]         bottom_y;
    logic [9:0]         right_x;
    logic [9:0]         top_y;
    logic [9:0]         left_x;
    logic               is_today;
    logic               in_month;
    logic signed [6:0]  day_number;
  } cell_word_t;

  typedef struct {
    cell_word_t word;
    logic       last;
  } cell_expect_t;

  // Predicts the 42 cells of each month request and checks the cell words
  class grid_scoreboard;
    cell_expect_t expected_cells[$];
    logic [9:0]   scr_w;
    logic [9:0]   scr_h;
    int mismatches;
    int requests;
    int cells_seen;
    int today_cells;
    int shown_cells;

    function new();
      scr_w = SCREEN_W_RST;
      scr_h = SCREEN_H_RST;
    endfunction

    function void set_reg(logic idx, logic [9:0] value);
      if (idx == REG_SCREEN_WIDTH) scr_w = value;
      else scr_h = value;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    function bit leap(int y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4) == 0;
    endfunction

    // Meaningless months count 31 days
    function int month_day_count(int y, int m);
      if (m < 1 || m > 12) return 31;
      if (m == 2 && leap(y)) return 29;
      return MONTH_DAYS[m - 1];
    endfunction

    // Sakamoto weekday of the first, 0 = Sunday; year zero goes to -1 for Jan/Feb
    function int first_weekday(int year, int m);
      int y;
      int w;
      if (m < 1 || m > 12) return 0;
      y = year;
      if (m < 3) y = y - 1;
      w = (y + y / 4 - y / 100 + y / 400 + WEEKDAY_SHIFT[m - 1] + 1) % 7;
      if (w < 0) w = w + 7;
      return w;
    endfunction

    function void note_request(request_t r);
      int W, H, cw, ch, dim, skip, idx, day, x0, x1, y0, y1, tx, ty, dw, year_now;
      bit inm, today;
      cell_expect_t e;
      W = scr_w;
      H = scr_h;
      cw = W / GRID_COLS;
      ch = (H > GRID_ORIGIN_Y) ? (H - GRID_ORIGIN_Y) / GRID_ROWS : 0;
      year_now = 2000 + int'(r.today_year_low) % 100;
      dim = month_day_count(r.view_year, r.req_month);
      skip = first_weekday(r.view_year, r.req_month);
      requests++;
      for (int row = 0; row < GRID_ROWS; row++) begin
        for (int col = 0; col < GRID_COLS; col++) begin
          idx = row * GRID_COLS + col;
          day = idx - skip + 1;
          x0 = col * cw;
          x1 = (col == GRID_COLS - 1) ? W - 1 : x0 + cw - 1;
          y0 = GRID_ORIGIN_Y + row * ch;
          y1 = (row == GRID_ROWS - 1) ? H - 1 : y0 + ch - 1;
          inm = day >= 1 && day <= dim;
          today = 1'b0;
          tx = 0;
          ty = 0;
          // Out-of-month cells keep their rectangle but carry no text
          if (inm) begin
            dw = ((day >= 10) ? 2 : 1) * GLYPH_WIDTH * 2;
            today = r.view_year == year_now && r.req_month == r.today_month &&
                    day == r.today_day;
            tx = x0 + (x1 - x0 + 1 - dw) / 2;
            ty = y0 + (y1 - y0 + 1 - DIGIT_HEIGHT) / 2;
          end
          e.word.day_number = 7'(day);
          e.word.in_month   = inm;
          e.word.is_today   = today;
          e.word.left_x     = 10'(x0);
          e.word.top_y      = 10'(y0);
          e.word.right_x    = 10'(x1);
          e.word.bottom_y   = 10'(y1);
          e.word.text_x     = 11'(tx);
          e.word.text_y     = 11'(ty);
          e.word.text_shown = inm && tx >= 0 && ty >= 0;
          e.last            = (idx == GRID_ROWS * GRID_COLS - 1);
          expected_cells.push_back(e);
        end
      end
    endfunction

    function void compare_field(string field, logic [10:0] want, logic [10:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cell word %0d: %s expected 0x%0h, got 0x%0h",
                   cells_seen, field, want, got);
      end
    endfunction

    function void check_cell(cell_word_t got, logic got_last);
      cell_expect_t want;
      cells_seen++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cell word %0d arrived with no cell expected", cells_seen);
      end else begin
        want = expected_cells.pop_front();
        if (want.word.is_today) today_cells++;
        if (want.word.text_shown) shown_cells++;
        compare_field("day_number", want.word.day_number, got.day_number);
        compare_field("in_month",   want.word.in_month,   got.in_month);
        compare_field("is_today",   want.word.is_today,   got.is_today);
        compare_field("left_x",     want.word.left_x,     got.left_x);
        compare_field("top_y",      want.word.top_y,      got.top_y);
        compare_field("right_x",    want.word.right_x,    got.right_x);
        compare_field("bottom_y",   want.word.bottom_y,   got.bottom_y);
        compare_field("text_x",     want.word.text_x,     got.text_x);
        compare_field("text_y",     want.word.text_y,     got.text_y);
        compare_field("text_shown", want.word.text_shown, got.text_shown);
        compare_field("last_cell",  want.last,            got_last);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = REG_SCREEN_WIDTH;
  logic [9:0]  cfg_data   = '0;

  grid_scoreboard board;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  calendar_month_grid_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Stall the cell stream at random
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 21);
  end

  // Check each accepted cell word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_cell(out_tdata, out_tlast);
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("calendar_month_grid_generator_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic request_t make_request(int vy, int vm, int tyl, int tm, int td);
    request_t r;
    r.fill           = '0;
    r.view_year      = 14'(vy);
    r.req_month      = 4'(vm);
    r.today_year_low = 7'(tyl);
    r.today_month    = 4'(tm);
    r.today_day      = 5'(td);
    return r;
  endfunction

  // Mostly well-formed dates, a share aimed at today's month, the rest raw bits
  function automatic request_t random_request();
    int kind;
    int tyl;
    int tm;
    kind = $urandom_range(99);
    tyl = $urandom_range(127);
    tm = $urandom_range(12, 1);
    if (kind < 30)
      return make_request(2000 + tyl % 100, tm, tyl, tm, $urandom_range(31, 1));
    if (kind < 55)
      return make_request($urandom_range(2100, 1900), $urandom_range(12, 1), tyl, tm,
                          $urandom_range(31, 1));
    if (kind < 75)
      return make_request($urandom_range(9999, 1), $urandom_range(12, 1), tyl, tm,
                          $urandom_range(31, 1));
    return make_request($urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Present one request word, idling before it at random; returns on a falling edge
  task automatic send_request(request_t r);
    if (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (!no_idle && $urandom_range(99) < 21) @(negedge clk);
    end
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop the request valid and wait until every expected cell has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic send_directed();
    send_request(make_request(0, 1, 0, 1, 1));           // year zero, January
    send_request(make_request(0, 2, 0, 2, 29));          // year zero, February
    send_request(make_request(0, 3, 0, 3, 1));
    send_request(make_request(1, 1, 1, 1, 1));           // year one, January
    send_request(make_request(2000, 2, 0, 2, 29));       // leap century, today
    send_request(make_request(1900, 2, 0, 2, 28));       // common century
    send_request(make_request(2024, 2, 124, 2, 29));     // today year wraps mod 100
    send_request(make_request(2099, 12, 99, 12, 31));    // today on the last day
    send_request(make_request(9999, 12, 0, 1, 1));
    send_request(make_request(16383, 15, 127, 15, 31));  // all field bits high
    send_request(make_request(2023, 0, 23, 0, 1));       // invalid month zero
    send_request(make_request(2023, 13, 23, 1, 1));
    send_request(make_request(2023, 14, 23, 14, 5));     // invalid month, today match
    send_request(make_request(2023, 5, 23, 5, 0));       // today day zero
    for (int m = 1; m <= 12; m++) send_request(make_request(2026, m, 26, 3, 15));
  endtask

  initial begin
    int widths [6];
    int heights [6];
    widths  = '{1023, 7, 640, 6, 0, 0};
    heights = '{1023, 128, 40, 79, 0, 0};
    widths[4]  = $urandom_range(1023, 7);
    heights[4] = $urandom_range(1023, 128);
    widths[5]  = $urandom_range(1023, 7);
    heights[5] = $urandom_range(1023, 128);
    board = new();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset screen size first, then one phase per register setting
    send_directed();
    send_random(PHASE_REQUESTS);
    for (int p = 0; p < 6; p++) begin
      drain();
      no_idle = (p == 1);
      write_reg(REG_SCREEN_WIDTH, 10'(widths[p]));
      write_reg(REG_SCREEN_HEIGHT, 10'(heights[p]));
      send_random(PHASE_REQUESTS);
    end
    drain();
    no_idle = 1'b0;
    repeat (20) @(posedge clk);

    $display("run covered %0d month requests and %0d cell words over 7 screen sizes",
             board.requests, board.cells_seen);
    $display("  %0d cells marked today, %0d cells with text shown, %0d mismatches",
             board.today_cells, board.shown_cells, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("calendar_month_grid_generator_test: PASS");
    end else begin
      $display("calendar_month_grid_generator_test: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/cmg_pkg.sv
sv/cmg_date.sv
sv/cmg_cell.sv
sv/calendar_month_grid_generator.sv
dv/calendar_month_grid_generator_test.sv
